[hdl/pias_pkg.sv]
// shared types and constants of the particle integrate / atlas step unit
package pias_pkg;

  localparam int COORD_W   = 20;
  localparam int MAX_ROWS  = 16;
  localparam int ROWS_W    = 5;
  localparam int INIT_W    = 60;
  localparam int CFG_IDX_W = 3;

  localparam int MUL_A_W = 33;
  localparam int MUL_B_W = 22;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;

  localparam int DIV_STEPS = 41;
  localparam int RC_STEPS  = 8;
  localparam int OF_STEPS  = 12;
  localparam int SQ_STEPS  = 22;
  localparam int CNT_W     = 6;

  localparam logic [23:0] ELAPSED_MAX = 24'hFFFFFF;
  localparam logic [21:0] DIST_MAX    = 22'h3FFFFF;

  localparam logic [CFG_IDX_W-1:0] REG_INIT_POS = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INIT_VEL = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GRAV_ACC = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_GRAV_FAC = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_LIFE     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_ROWS     = 3'd5;

  typedef enum logic [4:0] {
    OP_NONE, OP_LOAD, OP_RESPAWN,
    OP_G_MUL, OP_G_SAVE, OP_VY_MUL, OP_VY_ADD,
    OP_PX_MUL, OP_PX_ADD, OP_PY_MUL, OP_PY_ADD, OP_PZ_MUL, OP_PZ_ADD,
    OP_PG_MUL, OP_DIV_INIT, OP_DIV_STEP, OP_RC_INIT, OP_RC_STEP,
    OP_OF_INIT, OP_OF_STEP,
    OP_DX_MUL, OP_DX_ADD, OP_DY_MUL, OP_DY_ADD, OP_DZ_MUL, OP_DZ_ADD,
    OP_SQ_INIT, OP_SQ_STEP, OP_SQ_DONE, OP_OUT
  } op_t;

endpackage

[hdl/pias_ctrl.sv]
// sequencer: walks one request through the shared datapath and owns the handshakes
module pias_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  logic          in_func,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  output pias_pkg::op_t op
);
  import pias_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE, ST_RESPAWN,
    ST_G_MUL, ST_G_SAVE, ST_VY_MUL, ST_VY_ADD,
    ST_PX_MUL, ST_PX_ADD, ST_PY_MUL, ST_PY_ADD, ST_PZ_MUL, ST_PZ_ADD,
    ST_PG_MUL, ST_DIV_INIT, ST_DIV, ST_RC_INIT, ST_RC, ST_OF_INIT, ST_OF,
    ST_DX_MUL, ST_DX_ADD, ST_DY_MUL, ST_DY_ADD, ST_DZ_MUL, ST_DZ_ADD,
    ST_SQ_INIT, ST_SQ, ST_SQ_DONE, ST_FIN
  } state_t;

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             out_valid_r, out_valid_nxt;

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r & ~out_ready;
    op            = OP_NONE;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          op        = OP_LOAD;
          state_nxt = in_func ? ST_RESPAWN : ST_G_MUL;
        end
      end
      ST_RESPAWN:  begin op = OP_RESPAWN;  state_nxt = ST_FIN;      end
      ST_G_MUL:    begin op = OP_G_MUL;    state_nxt = ST_G_SAVE;   end
      ST_G_SAVE:   begin op = OP_G_SAVE;   state_nxt = ST_VY_MUL;   end
      ST_VY_MUL:   begin op = OP_VY_MUL;   state_nxt = ST_VY_ADD;   end
      ST_VY_ADD:   begin op = OP_VY_ADD;   state_nxt = ST_PX_MUL;   end
      ST_PX_MUL:   begin op = OP_PX_MUL;   state_nxt = ST_PX_ADD;   end
      ST_PX_ADD:   begin op = OP_PX_ADD;   state_nxt = ST_PY_MUL;   end
      ST_PY_MUL:   begin op = OP_PY_MUL;   state_nxt = ST_PY_ADD;   end
      ST_PY_ADD:   begin op = OP_PY_ADD;   state_nxt = ST_PZ_MUL;   end
      ST_PZ_MUL:   begin op = OP_PZ_MUL;   state_nxt = ST_PZ_ADD;   end
      ST_PZ_ADD:   begin op = OP_PZ_ADD;   state_nxt = ST_PG_MUL;   end
      ST_PG_MUL:   begin op = OP_PG_MUL;   state_nxt = ST_DIV_INIT; end
      ST_DIV_INIT: begin
        op        = OP_DIV_INIT;
        cnt_nxt   = CNT_W'(DIV_STEPS - 1);
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        op = OP_DIV_STEP;
        if (cnt_r == '0) state_nxt = ST_RC_INIT;
        else cnt_nxt = cnt_r - 1'b1;
      end
      ST_RC_INIT: begin
        op        = OP_RC_INIT;
        cnt_nxt   = CNT_W'(RC_STEPS - 1);
        state_nxt = ST_RC;
      end
      ST_RC: begin
        op = OP_RC_STEP;
        if (cnt_r == '0) state_nxt = ST_OF_INIT;
        else cnt_nxt = cnt_r - 1'b1;
      end
      ST_OF_INIT: begin
        op        = OP_OF_INIT;
        cnt_nxt   = CNT_W'(OF_STEPS - 1);
        state_nxt = ST_OF;
      end
      ST_OF: begin
        op = OP_OF_STEP;
        if (cnt_r == '0) state_nxt = ST_DX_MUL;
        else cnt_nxt = cnt_r - 1'b1;
      end
      ST_DX_MUL:   begin op = OP_DX_MUL;   state_nxt = ST_DX_ADD;   end
      ST_DX_ADD:   begin op = OP_DX_ADD;   state_nxt = ST_DY_MUL;   end
      ST_DY_MUL:   begin op = OP_DY_MUL;   state_nxt = ST_DY_ADD;   end
      ST_DY_ADD:   begin op = OP_DY_ADD;   state_nxt = ST_DZ_MUL;   end
      ST_DZ_MUL:   begin op = OP_DZ_MUL;   state_nxt = ST_DZ_ADD;   end
      ST_DZ_ADD:   begin op = OP_DZ_ADD;   state_nxt = ST_SQ_INIT;  end
      ST_SQ_INIT: begin
        op        = OP_SQ_INIT;
        cnt_nxt   = CNT_W'(SQ_STEPS - 1);
        state_nxt = ST_SQ;
      end
      ST_SQ: begin
        op = OP_SQ_STEP;
        if (cnt_r == '0) state_nxt = ST_SQ_DONE;
        else cnt_nxt = cnt_r - 1'b1;
      end
      ST_SQ_DONE:  begin op = OP_SQ_DONE;  state_nxt = ST_FIN;      end
      ST_FIN: begin
        // result register must be free before it is overwritten
        if (!out_valid_r || out_ready) begin
          op            = OP_OUT;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

`ifndef SYNTHESIS
  a_tick_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && !in_func) |=> (state_r == ST_G_MUL))
    else $error("tick request did not start the update");
  a_fin_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FIN && out_valid_r && !out_ready) |=> (state_r == ST_FIN))
    else $error("pending result overwritten");
  a_cnt_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> (cnt_r == '0))
    else $error("iteration counter not drained");
`endif

endmodule

[hdl/pias_dp.sv]
// datapath: config and particle state, shared multiplier, dividers and square root
module pias_dp (
  input  logic                              clk,
  input  logic                              rst_n,
  input  pias_pkg::op_t                     op,
  input  logic                              cfg_wr_en,
  input  logic [pias_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [pias_pkg::INIT_W-1:0]       cfg_data,
  input  logic [15:0]                       in_dt,
  input  logic signed [19:0]                in_cam_x,
  input  logic signed [19:0]                in_cam_y,
  input  logic signed [19:0]                in_cam_z,
  output logic signed [19:0]                out_pos_x,
  output logic signed [19:0]                out_pos_y,
  output logic signed [19:0]                out_pos_z,
  output logic                              out_alive,
  output logic [7:0]                        out_blend,
  output logic [11:0]                       out_first_col,
  output logic [11:0]                       out_first_row,
  output logic [11:0]                       out_next_col,
  output logic [11:0]                       out_next_row,
  output logic [21:0]                       out_cam_distance
);
  import pias_pkg::*;

  localparam int ACC_W = PROD_W + 1;

  // configuration
  logic [INIT_W-1:0] init_pos_r, init_vel_r;
  logic [15:0]       ga_r, gf_r;
  logic [23:0]       life_r;
  logic [ROWS_W-1:0] rows_r;

  // particle state
  logic signed [COORD_W-1:0] pos_r [3];
  logic signed [COORD_W-1:0] vel_r [3];
  logic [23:0]               elapsed_r;
  logic [7:0]                blend_r;
  logic [11:0]               off_r [4];
  logic [21:0]               dist_r;

  // request and working registers
  logic [15:0]               dt_r;
  logic signed [19:0]        cam_r [3];
  logic signed [31:0]        g_r;
  logic signed [PROD_W-1:0]  prod_r;
  logic [40:0]               div_q_r;
  logic [23:0]               div_rem_r;
  logic [7:0]                rc_q_r;
  logic [3:0]                rc_rem_r;
  logic                      last_r;
  logic [11:0]               of_q_r [4];
  logic [3:0]                of_rem_r [4];
  logic [42:0]               sum_r;
  logic [43:0]               sq_v_r, sq_b_r;
  logic [44:0]               sq_r_r;
  logic                      sq_sat_r;

  // result register
  logic signed [19:0]        o_pos_r [3];
  logic                      o_alive_r;
  logic [7:0]                o_blend_r;
  logic [11:0]               o_off_r [4];
  logic [21:0]               o_dist_r;

  logic [ROWS_W-1:0]         rows_eff;
  logic [8:0]                stages;
  logic [7:0]                stages_m1;
  logic [23:0]               life_eff;
  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic [1:0]                axis;
  logic signed [20:0]        dist_d;
  logic signed [ACC_W-1:0]   acc;
  logic [24:0]               e_sum;
  logic [24:0]               div_t;
  logic                      div_ge;
  logic [7:0]                i0;
  logic [4:0]                rc_t;
  logic                      rc_ge;
  logic [3:0]                col0, row0, col1, row1;
  logic [44:0]               sq_rb;
  logic                      sq_ge;

  function automatic logic signed [COORD_W-1:0] sat_coord(input logic signed [ACC_W-1:0] v);
    logic signed [ACC_W-1:0] hi, lo;
    hi = ACC_W'((2 ** (COORD_W - 1)) - 1);
    lo = -hi - ACC_W'(1);
    if (v > hi) return COORD_W'(hi);
    else if (v < lo) return COORD_W'(lo);
    else return COORD_W'(v);
  endfunction

  // position outputs are 20 signed bits whatever the state width
  function automatic logic signed [19:0] sat_out(input logic signed [ACC_W-1:0] v);
    logic signed [ACC_W-1:0] hi, lo;
    hi = ACC_W'((2 ** 19) - 1);
    lo = -hi - ACC_W'(1);
    if (v > hi) return 20'(hi);
    else if (v < lo) return 20'(lo);
    else return 20'(v);
  endfunction

  always_comb begin
    if (rows_r == '0) rows_eff = ROWS_W'(1);
    else if (rows_r > ROWS_W'(MAX_ROWS)) rows_eff = ROWS_W'(MAX_ROWS);
    else rows_eff = rows_r;
  end
  assign stages    = 9'(rows_eff * rows_eff);
  assign stages_m1 = 8'(stages - 9'd1);
  assign life_eff  = (life_r == '0) ? 24'd1 : life_r;

  always_comb begin
    case (op)
      OP_PY_MUL, OP_PY_ADD, OP_DY_MUL: axis = 2'd1;
      OP_PZ_MUL, OP_PZ_ADD, OP_DZ_MUL: axis = 2'd2;
      default:                         axis = 2'd0;
    endcase
  end

  assign dist_d = 21'(cam_r[axis]) - 21'(pos_r[axis]);

  // operand select for the one shared multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (op)
      OP_G_MUL: begin
        mul_a = MUL_A_W'($signed(ga_r));
        mul_b = MUL_B_W'($signed(gf_r));
      end
      OP_VY_MUL: begin
        mul_a = MUL_A_W'(g_r);
        mul_b = $signed({6'd0, dt_r});
      end
      OP_PX_MUL, OP_PY_MUL, OP_PZ_MUL: begin
        mul_a = MUL_A_W'(vel_r[axis]);
        mul_b = $signed({6'd0, dt_r});
      end
      OP_PG_MUL: begin
        mul_a = $signed({9'd0, elapsed_r});
        mul_b = $signed({13'd0, stages});
      end
      OP_DX_MUL, OP_DY_MUL, OP_DZ_MUL: begin
        mul_a = MUL_A_W'(dist_d);
        mul_b = MUL_B_W'(dist_d);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // floor shifts of the registered product
  always_comb begin
    if (op == OP_VY_ADD) acc = ACC_W'(vel_r[1]) + ACC_W'(prod_r >>> 24);
    else acc = ACC_W'(pos_r[axis]) + ACC_W'(prod_r >>> 16);
  end

  assign e_sum = {1'b0, elapsed_r} + {9'd0, dt_r};

  // restoring divide, progress by life
  assign div_t  = {div_rem_r, div_q_r[40]};
  assign div_ge = div_t >= {1'b0, life_eff};

  assign i0 = (div_q_r[40:8] > {25'd0, stages_m1}) ? stages_m1 : div_q_r[15:8];

  assign rc_t  = {rc_rem_r, rc_q_r[7]};
  assign rc_ge = rc_t >= rows_eff;

  always_comb begin
    col0 = rc_rem_r;
    row0 = rc_q_r[3:0];
    col1 = col0;
    row1 = row0;
    if (!last_r) begin
      if ({1'b0, col0} + 5'd1 == rows_eff) begin
        col1 = '0;
        row1 = row0 + 4'd1;
      end else begin
        col1 = col0 + 4'd1;
      end
    end
  end

  assign sq_rb = sq_r_r + {1'b0, sq_b_r};
  assign sq_ge = {1'b0, sq_v_r} >= sq_rb;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      init_pos_r <= '0;
      init_vel_r <= '0;
      ga_r       <= 16'hF630;
      gf_r       <= 16'd256;
      life_r     <= 24'd65536;
      rows_r     <= ROWS_W'(1);
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_INIT_POS: init_pos_r <= cfg_data;
        REG_INIT_VEL: init_vel_r <= cfg_data;
        REG_GRAV_ACC: ga_r       <= cfg_data[15:0];
        REG_GRAV_FAC: gf_r       <= cfg_data[15:0];
        REG_LIFE:     life_r     <= cfg_data[23:0];
        REG_ROWS:     rows_r     <= cfg_data[ROWS_W-1:0];
        default: ;
      endcase
    end
  end

  // architectural particle state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 3; i++) begin
        pos_r[i] <= '0;
        vel_r[i] <= '0;
      end
      for (int i = 0; i < 4; i++) off_r[i] <= '0;
      elapsed_r <= '0;
      blend_r   <= '0;
      dist_r    <= '0;
    end else begin
      case (op)
        OP_RESPAWN: begin
          for (int i = 0; i < 3; i++) begin
            pos_r[i] <= COORD_W'($signed(init_pos_r[20*i +: 20]));
            vel_r[i] <= COORD_W'($signed(init_vel_r[20*i +: 20]));
          end
          elapsed_r <= '0;
        end
        OP_VY_ADD: vel_r[1] <= sat_coord(acc);
        OP_PX_ADD: begin
          pos_r[axis] <= sat_coord(acc);
          elapsed_r   <= e_sum[24] ? ELAPSED_MAX : e_sum[23:0];
        end
        OP_PY_ADD, OP_PZ_ADD: pos_r[axis] <= sat_coord(acc);
        OP_RC_INIT: blend_r <= div_q_r[7:0];
        OP_DX_MUL: for (int i = 0; i < 4; i++) off_r[i] <= of_q_r[i];
        OP_SQ_DONE: begin
          if (sq_sat_r || sq_r_r > {23'd0, DIST_MAX}) dist_r <= DIST_MAX;
          else dist_r <= sq_r_r[21:0];
        end
        default: ;
      endcase
    end
  end

  // working registers, no reset needed
  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
    case (op)
      OP_LOAD: begin
        dt_r     <= in_dt;
        cam_r[0] <= in_cam_x;
        cam_r[1] <= in_cam_y;
        cam_r[2] <= in_cam_z;
      end
      OP_G_SAVE: g_r <= prod_r[31:0];
      OP_DIV_INIT: begin
        div_q_r   <= {prod_r[32:0], 8'd0};
        div_rem_r <= '0;
      end
      OP_DIV_STEP: begin
        div_rem_r <= div_ge ? 24'(div_t - {1'b0, life_eff}) : div_t[23:0];
        div_q_r   <= {div_q_r[39:0], div_ge};
      end
      OP_RC_INIT: begin
        rc_q_r   <= i0;
        rc_rem_r <= '0;
        last_r   <= (i0 == stages_m1);
      end
      OP_RC_STEP: begin
        rc_rem_r <= rc_ge ? 4'(rc_t - rows_eff) : rc_t[3:0];
        rc_q_r   <= {rc_q_r[6:0], rc_ge};
      end
      OP_OF_INIT: begin
        of_rem_r[0] <= col0;
        of_rem_r[1] <= row0;
        of_rem_r[2] <= col1;
        of_rem_r[3] <= row1;
        for (int i = 0; i < 4; i++) of_q_r[i] <= '0;
      end
      OP_OF_STEP: begin
        // four independent lanes, one quotient bit each
        for (int i = 0; i < 4; i++) begin
          if ({of_rem_r[i], 1'b0} >= rows_eff) begin
            of_rem_r[i] <= 4'({of_rem_r[i], 1'b0} - rows_eff);
            of_q_r[i]   <= {of_q_r[i][10:0], 1'b1};
          end else begin
            of_rem_r[i] <= {of_rem_r[i][2:0], 1'b0};
            of_q_r[i]   <= {of_q_r[i][10:0], 1'b0};
          end
        end
      end
      OP_DX_ADD: sum_r <= {1'b0, prod_r[41:0]};
      OP_DY_ADD, OP_DZ_ADD: sum_r <= sum_r + {1'b0, prod_r[41:0]};
      OP_SQ_INIT: begin
        sq_sat_r <= sum_r[42];
        sq_v_r   <= {sum_r[41:0], 2'b00};
        sq_r_r   <= '0;
        sq_b_r   <= 44'd1 << 42;
      end
      OP_SQ_STEP: begin
        if (sq_ge) begin
          sq_v_r <= 44'({1'b0, sq_v_r} - sq_rb);
          sq_r_r <= (sq_r_r >> 1) + {1'b0, sq_b_r};
        end else begin
          sq_r_r <= sq_r_r >> 1;
        end
        sq_b_r <= sq_b_r >> 2;
      end
      OP_OUT: begin
        for (int i = 0; i < 3; i++) o_pos_r[i] <= sat_out(ACC_W'(pos_r[i]));
        o_alive_r <= elapsed_r < life_eff;
        o_blend_r <= blend_r;
        for (int i = 0; i < 4; i++) o_off_r[i] <= off_r[i];
        o_dist_r  <= dist_r;
      end
      default: ;
    endcase
  end

  assign out_pos_x        = o_pos_r[0];
  assign out_pos_y        = o_pos_r[1];
  assign out_pos_z        = o_pos_r[2];
  assign out_alive        = o_alive_r;
  assign out_blend        = o_blend_r;
  assign out_first_col    = o_off_r[0];
  assign out_first_row    = o_off_r[1];
  assign out_next_col     = o_off_r[2];
  assign out_next_row     = o_off_r[3];
  assign out_cam_distance = o_dist_r;

endmodule

[hdl/particle_integrate_atlas_step_unit.sv]
// top level of the particle integrate / atlas step unit
//   channel | handshake          | payload
//   in      | in_valid/in_ready  | func, dt, cam_x/y/z
//   out     | out_valid/out_ready| pos_x/y/z, alive, blend, offsets, cam_distance
//   cfg     | cfg_wr_en          | cfg_index, cfg_data
// a tick request runs the progress divide, the row/column divide, the four-lane
// offset divide and the distance square root, plus the multiply steps
// a respawn request reloads the initial state; one request is in work at a time
// reset is synchronous and returns config and particle state to their defaults
// the next request is taken while the previous result waits in the output register
module particle_integrate_atlas_step_unit (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           in_func,
  input  logic [15:0]                    in_dt,
  input  logic signed [19:0]             in_cam_x,
  input  logic signed [19:0]             in_cam_y,
  input  logic signed [19:0]             in_cam_z,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic signed [19:0]             out_pos_x,
  output logic signed [19:0]             out_pos_y,
  output logic signed [19:0]             out_pos_z,
  output logic                           out_alive,
  output logic [7:0]                     out_blend,
  output logic [11:0]                    out_first_col,
  output logic [11:0]                    out_first_row,
  output logic [11:0]                    out_next_col,
  output logic [11:0]                    out_next_row,
  output logic [21:0]                    out_cam_distance,
  input  logic                           cfg_wr_en,
  input  logic [pias_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [pias_pkg::INIT_W-1:0]    cfg_data
);
  import pias_pkg::*;

  op_t op;

  pias_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_func   (in_func),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .op        (op)
  );

  pias_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .op               (op),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_dt            (in_dt),
    .in_cam_x         (in_cam_x),
    .in_cam_y         (in_cam_y),
    .in_cam_z         (in_cam_z),
    .out_pos_x        (out_pos_x),
    .out_pos_y        (out_pos_y),
    .out_pos_z        (out_pos_z),
    .out_alive        (out_alive),
    .out_blend        (out_blend),
    .out_first_col    (out_first_col),
    .out_first_row    (out_first_row),
    .out_next_col     (out_next_col),
    .out_next_row     (out_next_row),
    .out_cam_distance (out_cam_distance)
  );

endmodule

[test/tb_top.sv]
// self-checking bench for the particle integrate / atlas step unit
`timescale 1ns / 100ps

module tb_top;
  import pias_pkg::*;

  localparam bit TICK = 1'b0;
  localparam bit RESPAWN = 1'b1;
  localparam int CYCLE_LIMIT = 900000;

  typedef struct packed {
    logic        func;
    logic [15:0] dt;
    logic [19:0] cx, cy, cz;
  } step_req_t;

  typedef struct packed {
    logic [19:0] px, py, pz;
    logic        alive;
    logic [7:0]  blend;
    logic [11:0] fc, fr, nc, nr;
    logic [21:0] cam_dist;
  } step_rsp_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic in_func = 1'b0;
  logic [15:0] in_dt = '0;
  logic signed [19:0] in_cam_x = '0, in_cam_y = '0, in_cam_z = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [19:0] out_pos_x, out_pos_y, out_pos_z;
  logic out_alive;
  logic [7:0] out_blend;
  logic [11:0] out_first_col, out_first_row, out_next_col, out_next_row;
  logic [21:0] out_cam_distance;
  logic cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [INIT_W-1:0] cfg_data = '0;

  particle_integrate_atlas_step_unit uut (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // particle model state
  logic [59:0] m_init_pos, m_init_vel;
  logic signed [15:0] m_gacc, m_gfac;
  logic [23:0] m_life;
  logic [4:0] m_rows;
  longint m_pos[3], m_vel[3];
  longint unsigned m_elapsed;
  logic [7:0] m_blend;
  logic [11:0] m_ofs[4];
  logic [21:0] m_dist;

  step_req_t pending_reqs[$];
  step_rsp_t expected_rsps[$];
  int errors = 0;
  longint cycles = 0;
  bit hold_off = 0;
  int hold_len = 0;

  function automatic longint clamp_s(longint v, int w);
    longint hi, lo;
    hi = (longint'(1) <<< (w - 1)) - 1;
    lo = -hi - 1;
    return v > hi ? hi : (v < lo ? lo : v);
  endfunction

  function automatic longint sx20(logic [19:0] v);
    return longint'(signed'(v));
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic void load_initial();
    for (int i = 0; i < 3; i++) begin
      m_pos[i] = sx20(m_init_pos[20*i +: 20]);
      m_vel[i] = sx20(m_init_vel[20*i +: 20]);
    end
    m_elapsed = 0;
  endfunction

  task automatic model_reset();
    m_init_pos = '0;
    m_init_vel = '0;
    m_gacc = -16'sd2512;
    m_gfac = 16'sd256;
    m_life = 24'd65536;
    m_rows = 5'd1;
    load_initial();
    m_blend = '0;
    foreach (m_ofs[i]) m_ofs[i] = '0;
    m_dist = '0;
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [INIT_W-1:0] val);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    case (idx)
      REG_INIT_POS: m_init_pos = val[59:0];
      REG_INIT_VEL: m_init_vel = val[59:0];
      REG_GRAV_ACC: m_gacc = val[15:0];
      REG_GRAV_FAC: m_gfac = val[15:0];
      REG_LIFE:     m_life = val[23:0];
      REG_ROWS:     m_rows = val[4:0];
      default: ;
    endcase
  endtask

  // prediction of one accepted request
  function automatic step_rsp_t predict_step(step_req_t r);
    step_rsp_t o;
    longint g, cam[3], d;
    longint unsigned life, rows, stages, p, i0, i1, sum;
    life = m_life == 0 ? 1 : m_life;
    cam[0] = sx20(r.cx);
    cam[1] = sx20(r.cy);
    cam[2] = sx20(r.cz);
    if (r.func == RESPAWN) begin
      load_initial();
    end else begin
      g = longint'(m_gacc) * longint'(m_gfac);
      rows = m_rows == 0 ? 1 : (m_rows > MAX_ROWS ? MAX_ROWS : m_rows);
      stages = rows * rows;
      m_vel[1] = clamp_s(m_vel[1] + ((g * longint'(r.dt)) >>> 24), COORD_W);
      for (int i = 0; i < 3; i++)
        m_pos[i] = clamp_s(m_pos[i] + ((m_vel[i] * longint'(r.dt)) >>> 16), COORD_W);
      m_elapsed = m_elapsed + r.dt;
      if (m_elapsed > ELAPSED_MAX) m_elapsed = ELAPSED_MAX;
      p = ((m_elapsed * stages) << 8) / life;
      i0 = p >> 8;
      if (i0 > stages - 1) i0 = stages - 1;
      i1 = i0 < stages - 1 ? i0 + 1 : i0;
      m_blend = p[7:0];
      m_ofs[0] = 12'(((i0 % rows) << 12) / rows);
      m_ofs[1] = 12'(((i0 / rows) << 12) / rows);
      m_ofs[2] = 12'(((i1 % rows) << 12) / rows);
      m_ofs[3] = 12'(((i1 / rows) << 12) / rows);
      sum = 0;
      for (int i = 0; i < 3; i++) begin
        d = cam[i] - m_pos[i];
        if (d < 0) d = -d;
        sum += longint'(d) * longint'(d);
      end
      if (sum >= (64'd1 << 42)) m_dist = DIST_MAX;
      else begin
        p = int_sqrt(sum << 2);
        m_dist = p > DIST_MAX ? DIST_MAX : p[21:0];
      end
    end
    o.px = 20'(clamp_s(m_pos[0], 20));
    o.py = 20'(clamp_s(m_pos[1], 20));
    o.pz = 20'(clamp_s(m_pos[2], 20));
    o.alive = m_elapsed < life;
    o.blend = m_blend;
    o.fc = m_ofs[0];
    o.fr = m_ofs[1];
    o.nc = m_ofs[2];
    o.nr = m_ofs[3];
    o.cam_dist = m_dist;
    return o;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    errors++;
    $display("mismatch %s: got %0h want %0h at cycle %0d", what, got, want, cycles);
  endtask

  // driver: bursts and gaps
  int burst_left = 0, gap_left = 0;
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) begin
        expected_rsps.push_back(predict_step({in_func, in_dt, in_cam_x, in_cam_y, in_cam_z}));
        void'(pending_reqs.pop_front());
      end
      if ((in_valid && !in_ready)) begin
        // hold the request
      end else if (pending_reqs.size() != 0 && (in_valid && in_ready ? 1'b1 : 1'b1)) begin
        int idx;
        idx = (in_valid && in_ready) ? 0 : 0;
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pending_reqs.size() > 0 &&
                     !(in_valid && in_ready && pending_reqs.size() == 0)) begin
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
          end
          burst_left--;
          if (burst_left == 0) gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
          in_valid <= 1'b1;
          {in_func, in_dt, in_cam_x, in_cam_y, in_cam_z} <= pending_reqs[idx];
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver stall pattern plus the long hold-off
  int stall_phase = 0;
  always @(posedge clk) begin
    if (rst_n) begin
      stall_phase <= (stall_phase + 1) % 23;
      if (hold_off) begin
        out_ready <= 1'b0;
        hold_len <= hold_len + 1;
      end else if (stall_phase < 8) begin
        out_ready <= 1'b1;
      end else begin
        out_ready <= ($urandom_range(0, 3) != 0);
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    step_rsp_t w;
    cycles <= cycles + 1;
    if (rst_n && out_valid && out_ready) begin
      if (expected_rsps.size() == 0) begin
        report_mismatch("unexpected result", 0, 0);
      end else begin
        w = expected_rsps.pop_front();
        if (out_pos_x !== w.px) report_mismatch("pos_x", out_pos_x, w.px);
        if (out_pos_y !== w.py) report_mismatch("pos_y", out_pos_y, w.py);
        if (out_pos_z !== w.pz) report_mismatch("pos_z", out_pos_z, w.pz);
        if (out_alive !== w.alive) report_mismatch("alive", out_alive, w.alive);
        if (out_blend !== w.blend) report_mismatch("blend", out_blend, w.blend);
        if (out_first_col !== w.fc) report_mismatch("first_col", out_first_col, w.fc);
        if (out_first_row !== w.fr) report_mismatch("first_row", out_first_row, w.fr);
        if (out_next_col !== w.nc) report_mismatch("next_col", out_next_col, w.nc);
        if (out_next_row !== w.nr) report_mismatch("next_row", out_next_row, w.nr);
        if (out_cam_distance !== w.cam_dist)
          report_mismatch("cam_distance", out_cam_distance, w.cam_dist);
      end
    end
    if (cycles > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  function automatic step_req_t rand_req(bit near_cam);
    step_req_t r;
    r.func = ($urandom_range(0, 15) == 0) ? RESPAWN : TICK;
    case ($urandom_range(0, 3))
      0: r.dt = 16'($urandom_range(0, 255));
      1: r.dt = 16'($urandom_range(0, 65535));
      2: r.dt = 16'hFFFF;
      default: r.dt = 16'($urandom_range(256, 4096));
    endcase
    if (near_cam) begin
      r.cx = 20'($urandom_range(0, 2047) - 1024);
      r.cy = 20'($urandom_range(0, 2047) - 1024);
      r.cz = 20'($urandom_range(0, 2047) - 1024);
    end else begin
      r.cx = 20'($urandom);
      r.cy = 20'($urandom);
      r.cz = 20'($urandom);
    end
    return r;
  endfunction

  task automatic wait_drained();
    while (pending_reqs.size() != 0 || in_valid || expected_rsps.size() != 0)
      @(posedge clk);
    repeat (150) @(posedge clk);
  endtask

  task automatic queue_phase(int n);
    for (int i = 0; i < n; i++) pending_reqs.push_back(rand_req($urandom_range(0, 1)));
    wait_drained();
  endtask

  task automatic random_settings();
    write_reg(REG_INIT_POS, INIT_W'({$urandom, $urandom}));
    write_reg(REG_INIT_VEL, INIT_W'({$urandom, $urandom}));
    write_reg(REG_GRAV_ACC, INIT_W'($urandom));
    write_reg(REG_GRAV_FAC, INIT_W'($urandom));
    write_reg(REG_LIFE, INIT_W'(($urandom_range(0, 1) != 0) ? $urandom_range(1, 70000)
                                                   : $urandom_range(0, 24'hFFFFFF)));
    write_reg(REG_ROWS, INIT_W'($urandom_range(0, 31)));
  endtask

  initial begin
    step_req_t r;
    model_reset();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: reset values, extremes of fields, respawn
    pending_reqs.push_back('{TICK, 16'd0, 20'h0, 20'h0, 20'h0});
    pending_reqs.push_back('{TICK, 16'hFFFF, 20'h7FFFF, 20'h80000, 20'h7FFFF});
    pending_reqs.push_back('{TICK, 16'h8000, 20'h80000, 20'h7FFFF, 20'h80000});
    pending_reqs.push_back('{RESPAWN, 16'hFFFF, 20'hFFFFF, 20'h0, 20'h55555});
    wait_drained();
    write_reg(REG_INIT_POS, {20'h7FFFF, 20'h80000, 20'h7FFFF});
    write_reg(REG_INIT_VEL, {20'h80000, 20'h7FFFF, 20'h80000});
    write_reg(REG_GRAV_ACC, INIT_W'(16'h8000));
    write_reg(REG_GRAV_FAC, INIT_W'(16'h8000));
    write_reg(REG_LIFE, INIT_W'(24'd0));
    write_reg(REG_ROWS, INIT_W'(5'd31));
    pending_reqs.push_back('{RESPAWN, 16'd0, 20'h0, 20'h0, 20'h0});
    for (int i = 0; i < 6; i++) pending_reqs.push_back('{TICK, 16'hFFFF, 20'h80000, 20'h7FFFF, 20'h0});
    wait_drained();
    write_reg(REG_LIFE, INIT_W'(24'hFFFFFF));
    write_reg(REG_ROWS, INIT_W'(5'd16));
    write_reg(REG_GRAV_ACC, INIT_W'(16'h7FFF));
    write_reg(REG_GRAV_FAC, INIT_W'(16'h7FFF));
    pending_reqs.push_back('{RESPAWN, 16'd0, 20'h0, 20'h0, 20'h0});
    for (int i = 0; i < 4; i++) pending_reqs.push_back('{TICK, 16'hFFFF, 20'h1, 20'h2, 20'h3});
    wait_drained();
    write_reg(REG_ROWS, INIT_W'(5'd0));
    write_reg(REG_LIFE, INIT_W'(24'd1));
    pending_reqs.push_back('{TICK, 16'd1, 20'h0, 20'h0, 20'h0});
    pending_reqs.push_back('{TICK, 16'd0, 20'h0, 20'h0, 20'h0});
    wait_drained();

    // long receiver hold-off while the sender keeps offering
    hold_off = 1;
    for (int i = 0; i < 20; i++) pending_reqs.push_back(rand_req(1));
    while (hold_len < 600) @(posedge clk);
    hold_off = 0;
    wait_drained();

    // random phases under several settings
    for (int ph = 0; ph < 13; ph++) begin
      random_settings();
      queue_phase(100);
    end

    if (errors == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

endmodule

[filelist.f]
hdl/pias_pkg.sv
hdl/pias_ctrl.sv
hdl/pias_dp.sv
hdl/particle_integrate_atlas_step_unit.sv
test/tb_top.sv
